@@ hdl/complex_arithmetic_unit_assert.svh @@
// ----------------------------------------------------------------------------
// complex_arithmetic_unit assertion macros
// concurrent assertion wrappers, empty under synthesis
// ----------------------------------------------------------------------------
`ifndef COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH
`define COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define CAU_ASSERT_IMP(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");
`define CAU_ASSERT_NXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");
`else
`define CAU_ASSERT_IMP(label, clk, rst_n, a, c)
`define CAU_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

@@ hdl/cau_pkg.sv @@
// ----------------------------------------------------------------------------
// cau_pkg
// shared types, mode codes, CORDIC step count and arctangent table of the complex arithmetic unit
// ----------------------------------------------------------------------------
package cau_pkg;
	typedef enum logic [2:0] {
		MODE_ADD = 3'd0,
		MODE_MUL = 3'd1,
		MODE_DIV = 3'd2,
		MODE_PAR = 3'd3,
		MODE_POL = 3'd4
	} mode_t;

	localparam int CORDIC_STEPS = 32;

	function automatic logic [31:0] atan_lut(input logic [4:0] i);
		logic [31:0] r;
		case (i)
			5'd0: r = 32'h20000000; 5'd1: r = 32'h12E4051E; 5'd2: r = 32'h09FB385B;
			5'd3: r = 32'h051111D4; 5'd4: r = 32'h028B0D43; 5'd5: r = 32'h0145D7E1;
			5'd6: r = 32'h00A2F61E; 5'd7: r = 32'h00517C55; 5'd8: r = 32'h0028BE53;
			5'd9: r = 32'h00145F2F; 5'd10: r = 32'h000A2F98; 5'd11: r = 32'h000517CC;
			5'd12: r = 32'h00028BE6; 5'd13: r = 32'h000145F3; 5'd14: r = 32'h0000A2FA;
			5'd15: r = 32'h0000517D; 5'd16: r = 32'h000028BE; 5'd17: r = 32'h0000145F;
			5'd18: r = 32'h00000A30; 5'd19: r = 32'h00000518; 5'd20: r = 32'h0000028C;
			5'd21: r = 32'h00000146; 5'd22: r = 32'h000000A3; 5'd23: r = 32'h00000051;
			5'd24: r = 32'h00000029; 5'd25: r = 32'h00000014; 5'd26: r = 32'h0000000A;
			5'd27: r = 32'h00000005; 5'd28: r = 32'h00000003; 5'd29: r = 32'h00000001;
			5'd30: r = 32'h00000001; default: r = 32'h00000000;
		endcase
		return r;
	endfunction
endpackage

@@ hdl/cau_cell.sv @@
// ----------------------------------------------------------------------------
// cau_cell
// one cell of the pipeline chain: a restoring divide step for both result
// parts, a square root step and a vectoring rotation step
// ----------------------------------------------------------------------------
module cau_cell #(
	parameter int NW = 200,
	parameter int DW = 140,
	parameter int QW = 40,
	parameter int SW = 64,
	parameter int CW = 66,
	parameter int QB = 1,
	parameter int SB = 2,
	parameter int QLO = 0,
	parameter int SLO = 0,
	parameter int IDX = 0,
	parameter int PW = 8
) (
	input  logic          clk,
	input  logic          en,
	input  logic [NW-1:0] nr_i,
	input  logic [NW-1:0] ni_i,
	input  logic [DW-1:0] d_i,
	input  logic [QW-1:0] qr_i,
	input  logic [QW-1:0] qi_i,
	input  logic [SW-1:0] sx_i,
	input  logic [SW-1:0] sr_i,
	input  logic signed [CW-1:0] cx_i,
	input  logic signed [CW-1:0] cy_i,
	input  logic [31:0]   cz_i,
	input  logic [PW-1:0] side_i,
	output logic [NW-1:0] nr_o,
	output logic [NW-1:0] ni_o,
	output logic [DW-1:0] d_o,
	output logic [QW-1:0] qr_o,
	output logic [QW-1:0] qi_o,
	output logic [SW-1:0] sx_o,
	output logic [SW-1:0] sr_o,
	output logic signed [CW-1:0] cx_o,
	output logic signed [CW-1:0] cy_o,
	output logic [31:0]   cz_o,
	output logic [PW-1:0] side_o
);
	logic [NW-1:0] nr_n, ni_n;
	logic [QW-1:0] qr_n, qi_n;
	logic [SW-1:0] sx_n, sr_n;
	logic signed [CW-1:0] cx_n, cy_n;
	logic [31:0] cz_n;

	always_comb begin
		logic [NW-1:0] ds;
		logic [SW-1:0] bt, acc;
		nr_n = nr_i;
		ni_n = ni_i;
		qr_n = qr_i;
		qi_n = qi_i;
		for (int k = QB - 1; k >= 0; k--) begin
			ds = NW'(d_i) << (QLO + k);
			if (nr_n >= ds) begin
				nr_n = nr_n - ds;
				qr_n[QLO + k] = 1'b1;
			end
			if (ni_n >= ds) begin
				ni_n = ni_n - ds;
				qi_n[QLO + k] = 1'b1;
			end
		end
		sx_n = sx_i;
		sr_n = sr_i;
		for (int k = SB - 1; k >= 0; k--) begin
			bt = SW'(1) << (2 * (SLO + k));
			acc = sr_n + bt;
			if (sx_n >= acc) begin
				sx_n = sx_n - acc;
				sr_n = (sr_n >> 1) + bt;
			end else begin
				sr_n = sr_n >> 1;
			end
		end
		if (cy_i >= 0) begin
			cx_n = cx_i + (cy_i >>> IDX);
			cy_n = cy_i - (cx_i >>> IDX);
			cz_n = cz_i + cau_pkg::atan_lut(5'(IDX));
		end else begin
			cx_n = cx_i - (cy_i >>> IDX);
			cy_n = cy_i + (cx_i >>> IDX);
			cz_n = cz_i - cau_pkg::atan_lut(5'(IDX));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nr_o   <= nr_n;
			ni_o   <= ni_n;
			d_o    <= d_i;
			qr_o   <= qr_n;
			qi_o   <= qi_n;
			sx_o   <= sx_n;
			sr_o   <= sr_n;
			cx_o   <= cx_n;
			cy_o   <= cy_n;
			cz_o   <= cz_n;
			side_o <= side_i;
		end
	end
endmodule

@@ hdl/complex_arithmetic_unit.sv @@
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// pipelined complex add, multiply, divide, parallel combination and polar form
// on signed fixed-point operands
// ----------------------------------------------------------------------------
// channel  signals                           direction
// in       valid stall mode a_re a_im b_re b_im  sink
// out      valid stall res_re res_im div_zero saturated  source
// one beat accepted per cycle unless a stalled result beat holds the pipeline;
// a result beat passes 3 front stages, 32 cells and 1 output stage
// reset clears the stage valid bits only
// a stalled result beat freezes the whole pipeline; the input stalls with it
module complex_arithmetic_unit #(
	parameter int DATA_WIDTH = 16,
	parameter int FRAC_BITS  = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [2:0]                   mode,
	input  logic signed [DATA_WIDTH-1:0] a_re,
	input  logic signed [DATA_WIDTH-1:0] a_im,
	input  logic signed [DATA_WIDTH-1:0] b_re,
	input  logic signed [DATA_WIDTH-1:0] b_im,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [DATA_WIDTH-1:0] res_re,
	output logic signed [DATA_WIDTH-1:0] res_im,
	output logic                         div_zero,
	output logic                         saturated
);
	`include "complex_arithmetic_unit_assert.svh"

	localparam int W   = DATA_WIDTH;
	localparam int PW1 = 2 * W + 2;
	localparam int NW  = 3 * W + FRAC_BITS + 6;
	localparam int DW  = 2 * W + 4;
	localparam int QW  = W + 1;
	localparam int NC  = cau_pkg::CORDIC_STEPS;
	localparam int QB  = (QW + NC - 1) / NC;
	localparam int SW  = 2 * W + 2;
	localparam int SB  = (SW / 2 + NC - 1) / NC;
	localparam int CW  = W + 31;
	localparam int PWS = 3 + 2 + 1 + 1 + 1;

	logic en;
	logic [NC+3:0] vld_q;
	assign en = !(out_valid && out_stall);
	assign in_stall = !en;
	assign out_valid = vld_q[NC+3];

	// stage 1: sums and products of operand parts
	logic [2:0] m_s1;
	logic signed [W:0] sr_s1, si_s1, ar_s1, ai_s1;
	logic signed [PW1-1:0] pr_s1, pi_s1, nre_s1, nim_s1, bb_s1, aa_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			m_s1   <= mode;
			ar_s1  <= (W+1)'(a_re);
			ai_s1  <= (W+1)'(a_im);
			sr_s1  <= (W+1)'(a_re) + (W+1)'(b_re);
			si_s1  <= (W+1)'(a_im) + (W+1)'(b_im);
			pr_s1  <= PW1'(a_re * b_re) - PW1'(a_im * b_im);
			pi_s1  <= PW1'(a_re * b_im) + PW1'(a_im * b_re);
			nre_s1 <= PW1'(a_re * b_re) + PW1'(a_im * b_im);
			nim_s1 <= PW1'(a_im * b_re) - PW1'(a_re * b_im);
			bb_s1  <= PW1'(b_re * b_re) + PW1'(b_im * b_im);
			aa_s1  <= PW1'(a_re * a_re) + PW1'(a_im * a_im);
		end
	end
	logic signed [2*W+3:0] ssq;
	assign ssq = (2*W+4)'(sr_s1 * sr_s1) + (2*W+4)'(si_s1 * si_s1);

	// stage 2: squared magnitude of the operand sum, the parallel denominator
	logic [2:0] m_s2;
	logic signed [W:0] sr_s2, si_s2, ar_s2, ai_s2;
	logic signed [PW1-1:0] pr_s2, pi_s2, nre_s2, nim_s2, bb_s2, aa_s2;
	logic signed [2*W+3:0] ss_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			m_s2 <= m_s1; sr_s2 <= sr_s1; si_s2 <= si_s1; ar_s2 <= ar_s1; ai_s2 <= ai_s1;
			pr_s2 <= pr_s1; pi_s2 <= pi_s1; nre_s2 <= nre_s1; nim_s2 <= nim_s1;
			bb_s2 <= bb_s1; aa_s2 <= aa_s1; ss_s2 <= ssq;
		end
	end

	// stage 3: numerator and denominator per mode, magnitude and sign split, root and CORDIC inputs
	localparam int XW = 3 * W + 4;
	logic signed [XW-1:0] p_rr, p_ii, p_ir, p_ri;
	assign p_rr = XW'(pr_s2 * sr_s2);
	assign p_ii = XW'(pi_s2 * si_s2);
	assign p_ir = XW'(pi_s2 * sr_s2);
	assign p_ri = XW'(pr_s2 * si_s2);

	logic [NW-1:0] nr_s3, ni_s3;
	logic [DW-1:0] d_s3;
	logic [PWS-1:0] side_s3;
	logic [SW-1:0] sq_s3;
	logic signed [CW-1:0] cx_s3, cy_s3;
	logic [31:0] cz_s3;
	always_ff @(posedge clk) begin
		logic signed [NW:0] n_re, n_im;
		logic [DW-1:0] dd;
		logic dz, zr;
		logic signed [W:0] cx, cy;
		logic [31:0] cz;
		if (en) begin
			n_re = '0; n_im = '0; dd = DW'(1); dz = 1'b0;
			case (m_s2)
				cau_pkg::MODE_ADD: begin
					n_re = (NW+1)'(sr_s2);
					n_im = (NW+1)'(si_s2);
				end
				cau_pkg::MODE_MUL: begin
					n_re = (NW+1)'(pr_s2);
					n_im = (NW+1)'(pi_s2);
					dd = DW'(1) << FRAC_BITS;
				end
				cau_pkg::MODE_DIV: begin
					n_re = (NW+1)'(nre_s2) <<< FRAC_BITS;
					n_im = (NW+1)'(nim_s2) <<< FRAC_BITS;
					dd = DW'(bb_s2);
					dz = (bb_s2 == 0);
				end
				cau_pkg::MODE_PAR: begin
					n_re = (NW+1)'(p_rr) + (NW+1)'(p_ii);
					n_im = (NW+1)'(p_ir) - (NW+1)'(p_ri);
					dd = DW'(ss_s2);
					dz = (ss_s2 == 0);
				end
				default: ;
			endcase
			if (dz) begin
				n_re = '0; n_im = '0; dd = DW'(1);
			end
			// round: q = (2|n| + d) / (2d)
			nr_s3 <= NW'(((n_re < 0) ? -n_re : n_re) <<< 1) + NW'(dd);
			ni_s3 <= NW'(((n_im < 0) ? -n_im : n_im) <<< 1) + NW'(dd);
			d_s3 <= dd << 1;
			sq_s3 <= SW'(aa_s2);
			zr = (ar_s2 == 0) && (ai_s2 == 0);
			cx = ar_s2; cy = ai_s2; cz = '0;
			if (ar_s2 < 0) begin
				cx = -ar_s2; cy = -ai_s2; cz = 32'h80000000;
			end
			cx_s3 <= CW'(cx) <<< 28;
			cy_s3 <= CW'(cy) <<< 28;
			cz_s3 <= cz;
			side_s3 <= {m_s2, n_re < 0, n_im < 0, dz, zr,
				(m_s2 == cau_pkg::MODE_ADD || m_s2 == cau_pkg::MODE_MUL ||
				 m_s2 == cau_pkg::MODE_DIV || m_s2 == cau_pkg::MODE_PAR ||
				 m_s2 == cau_pkg::MODE_POL)};
		end
	end

	// cell chain
	logic [NW-1:0] nr_c [NC+1];
	logic [NW-1:0] ni_c [NC+1];
	logic [DW-1:0] d_c [NC+1];
	logic [QW-1:0] qr_c [NC+1];
	logic [QW-1:0] qi_c [NC+1];
	logic [SW-1:0] sx_c [NC+1];
	logic [SW-1:0] sr_c [NC+1];
	logic signed [CW-1:0] cx_c [NC+1];
	logic signed [CW-1:0] cy_c [NC+1];
	logic [31:0] cz_c [NC+1];
	logic [PWS-1:0] sd_c [NC+1];
	assign nr_c[0] = nr_s3; assign ni_c[0] = ni_s3; assign d_c[0] = d_s3;
	assign qr_c[0] = '0; assign qi_c[0] = '0;
	assign sx_c[0] = sq_s3; assign sr_c[0] = '0;
	assign cx_c[0] = cx_s3; assign cy_c[0] = cy_s3; assign cz_c[0] = cz_s3;
	assign sd_c[0] = side_s3;

	for (genvar g = 0; g < NC; g++) begin : g_cell
		localparam int QHI = QW - g * QB;
		localparam int SHI = SW / 2 - g * SB;
		localparam int QBG = (QHI <= 0) ? 0 : ((QHI < QB) ? QHI : QB);
		localparam int SBG = (SHI <= 0) ? 0 : ((SHI < SB) ? SHI : SB);
		localparam int QLO = (QHI <= 0) ? 0 : QHI - QBG;
		localparam int SLO = (SHI <= 0) ? 0 : SHI - SBG;
		// cell g handles quotient bits QLO..QHI-1 and root bits SLO..SHI-1
		cau_cell #(.NW(NW), .DW(DW), .QW(QW), .SW(SW), .CW(CW),
			.QB(QBG), .SB(SBG), .QLO(QLO), .SLO(SLO), .IDX(g), .PW(PWS)) u_cell (
			.clk(clk), .en(en),
			.nr_i(nr_c[g]), .ni_i(ni_c[g]), .d_i(d_c[g]),
			.qr_i(qr_c[g]), .qi_i(qi_c[g]),
			.sx_i(sx_c[g]), .sr_i(sr_c[g]),
			.cx_i(cx_c[g]), .cy_i(cy_c[g]), .cz_i(cz_c[g]), .side_i(sd_c[g]),
			.nr_o(nr_c[g+1]), .ni_o(ni_c[g+1]), .d_o(d_c[g+1]),
			.qr_o(qr_c[g+1]), .qi_o(qi_c[g+1]), .sx_o(sx_c[g+1]), .sr_o(sr_c[g+1]),
			.cx_o(cx_c[g+1]), .cy_o(cy_c[g+1]), .cz_o(cz_c[g+1]),
			.side_o(sd_c[g+1]));
	end

	// top quotient bit set means the quotient is beyond range
	logic [QW-1:0] qr_f, qi_f;
	assign qr_f = qr_c[NC];
	assign qi_f = qi_c[NC];

	// output stage: sign, saturate, round the phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (en) vld_q <= {vld_q[NC+2:0], in_valid};
	end

	always_ff @(posedge clk) begin
		logic [2:0] m;
		logic ngr, ngi, dz, zr, ok, st;
		logic [QW-1:0] lp, ln;
		logic [W-1:0] vr, vi;
		logic [SW-1:0] mg;
		logic [31:0] z;
		if (en && vld_q[NC+2]) begin
			{m, ngr, ngi, dz, zr, ok} = sd_c[NC];
			ln = QW'(1) << (W - 1);
			lp = ln - QW'(1);
			st = 1'b0;
			vr = '0; vi = '0;
			if (m == cau_pkg::MODE_POL) begin
				mg = sr_c[NC] + SW'(sx_c[NC] > sr_c[NC]);
				if (mg > SW'(lp)) begin
					vr = W'(lp); st = 1'b1;
				end else vr = W'(mg);
				z = zr ? 32'h0 : cz_c[NC];
				if (W < 32) z = z + (32'd1 << (31 - W + 1 - 1 + ((W < 32) ? 0 : 0)));
				vi = W'(z >> (32 - W));
				if (zr) vi = '0;
			end else if (ok && !dz) begin
				if (ngr) begin
					if (qr_f > ln) begin vr = W'(ln); st = 1'b1; end
					else vr = W'(-qr_f);
				end else begin
					if (qr_f > lp) begin vr = W'(lp); st = 1'b1; end
					else vr = W'(qr_f);
				end
				if (ngi) begin
					if (qi_f > ln) begin vi = W'(ln); st = 1'b1; end
					else vi = W'(-qi_f);
				end else begin
					if (qi_f > lp) begin vi = W'(lp); st = 1'b1; end
					else vi = W'(qi_f);
				end
			end
			res_re    <= vr;
			res_im    <= vi;
			div_zero  <= dz && (m == cau_pkg::MODE_DIV || m == cau_pkg::MODE_PAR);
			saturated <= st;
		end
	end

	`CAU_ASSERT_IMP(a_dz_clean, clk, arst_n, out_valid && div_zero, {res_re, res_im, saturated} == '0)
	`CAU_ASSERT_IMP(a_stall_prop, clk, arst_n, out_valid && out_stall, in_stall)
	`CAU_ASSERT_NXT(a_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(res_re))
endmodule
